// ===== sv/pct_pkg.sv =====
// Shared types, result kinds and helpers for the pragma comment tokenizer.
package pct_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [6:0] TAB_WIDTH_RESET = 7'd8;

   localparam logic [3:0] KIND_BODY    = 4'd0;
   localparam logic [3:0] KIND_KEYWORD = 4'd1;
   localparam logic [3:0] KIND_IDENT   = 4'd2;
   localparam logic [3:0] KIND_STRING  = 4'd3;
   localparam logic [3:0] KIND_OPEN    = 4'd4;
   localparam logic [3:0] KIND_CLOSE   = 4'd5;
   localparam logic [3:0] KIND_COMMA   = 4'd6;
   localparam logic [3:0] KIND_GARBAGE = 4'd7;
   localparam logic [3:0] KIND_END     = 4'd8;
   localparam logic [3:0] KIND_ERROR   = 4'd9;
   localparam logic [3:0] KIND_DROPPED = 4'd10;

   typedef struct packed {
      logic [7:0]  ch;
      logic        first;
      logic [23:0] start_line;
      logic [15:0] start_column;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  data;
      logic [15:0] token_length;
      logic [23:0] token_line;
      logic [15:0] token_column;
      logic [23:0] now_line;
      logic [15:0] now_column;
      logic        last;
   } rsp_type;

   // One result without the position shared by all results of a character.
   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  data;
      logic [15:0] token_length;
      logic [23:0] token_line;
      logic [15:0] token_column;
   } tok_type;

   // Everything one character produces: one or two results.
   typedef struct packed {
      logic        two;
      tok_type     slot0;
      tok_type     slot1;
      logic [23:0] now_line;
      logic [15:0] now_column;
   } rec_type;

   function automatic tok_type make_tok(input logic [3:0] kind, input logic [7:0] data,
                                        input logic [15:0] len, input logic [23:0] line,
                                        input logic [15:0] column);
      tok_type t;
      t.kind         = kind;
      t.data         = data;
      t.token_length = len;
      t.token_line   = line;
      t.token_column = column;
      return t;
   endfunction

   // Characters of the one keyword, "pragma".
   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h70;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h61;
         3'd3:    c = 8'h67;
         3'd4:    c = 8'h6D;
         3'd5:    c = 8'h61;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== sv/pct_front.sv =====
// Front end: takes characters, keeps scan state and position, builds result records.
module pct_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  pct_pkg::req_type  req_payload,
   output logic              req_full,
   input  logic              csr_valid,
   input  logic [6:0]        csr_data,
   output logic              csr_ready,
   input  logic              rec_full,
   output logic              rec_push,
   output pct_pkg::rec_type  rec_data
);

   localparam logic [1:0] M_IDLE   = 2'd0;
   localparam logic [1:0] M_WORD   = 2'd1;
   localparam logic [1:0] M_STRING = 2'd2;
   localparam logic [1:0] M_DONE   = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOLAR = 8'h24;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam logic [23:0] LINE_MAX = '1;
   localparam logic [15:0] COL_MAX  = '1;
   localparam logic [15:0] LEN_MAX  = '1;

   logic [6:0]  tab_ff, tab_in;
   logic [1:0]  mode_ff, mode_in;
   logic [23:0] line_ff, line_in;
   logic [15:0] col_ff, col_in;
   logic [23:0] tline_ff, tline_in;
   logic [15:0] tcol_ff, tcol_in;
   logic [15:0] tlen_ff, tlen_in;
   logic        kwm_ff, kwm_in;
   logic        esc_ff, esc_in;
   logic        seen_ff, seen_in;
   logic        fkw_ff, fkw_in;

   logic [7:0]  ch;
   logic        is_letter, is_word, is_blank;
   logic        accept;
   logic [16:0] col_sum;
   logic [6:0]  step;
   logic        do_idle, idle_hit, kw;
   logic [1:0]  nres;
   pct_pkg::tok_type idle_tok, slot0, slot1;

   assign ch        = req_payload.ch;
   assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
   assign is_word   = is_letter || (ch >= 8'h30 && ch <= 8'h39) || ch == CH_UNDER ||
                      ch == CH_DOLAR;
   assign is_blank  = ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR ||
                      ch == CH_FF;

   assign req_full  = rec_full;
   assign accept    = req_push && !rec_full;
   assign csr_ready = 1'b1;
   assign tab_in    = (csr_valid && csr_ready) ? csr_data : tab_ff;

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      tlen_in  = tlen_ff;
      kwm_in   = kwm_ff;
      esc_in   = esc_ff;
      seen_in  = seen_ff;
      fkw_in   = fkw_ff;
      nres     = 2'd0;
      slot0    = '0;
      slot1    = '0;
      idle_tok = '0;
      idle_hit = 1'b0;
      do_idle  = 1'b0;
      kw       = 1'b0;
      step     = 7'd1;
      col_sum  = '0;

      if (req_payload.first) begin
         mode_in  = M_IDLE;
         line_in  = req_payload.start_line;
         col_in   = req_payload.start_column;
         tline_in = '0;
         tcol_in  = '0;
         tlen_in  = '0;
         kwm_in   = 1'b1;
         esc_in   = 1'b0;
         seen_in  = 1'b0;
         fkw_in   = 1'b0;
      end

      if (mode_in != M_DONE) begin
         // position moves before the character is classified
         if (ch == CH_LF) begin
            if (line_in != LINE_MAX) line_in = line_in + 24'd1;
            col_in = '0;
         end else begin
            step    = (ch == CH_TAB) ? tab_ff : 7'd1;
            col_sum = {1'b0, col_in} + {10'd0, step};
            col_in  = col_sum[16] ? COL_MAX : col_sum[15:0];
         end

         case (mode_in)
            M_WORD: begin
               if (is_word) begin
                  if (!(tlen_in < 16'd6 && ch == pct_pkg::keyword_char(tlen_in[2:0])))
                     kwm_in = 1'b0;
                  slot0 = pct_pkg::make_tok(pct_pkg::KIND_BODY, ch, '0, tline_in, tcol_in);
                  if (tlen_in != LEN_MAX) tlen_in = tlen_in + 16'd1;
                  nres = 2'd1;
               end else begin
                  kw = kwm_in && tlen_in == 16'd6;
                  if (!seen_in) begin
                     seen_in = 1'b1;
                     fkw_in  = kw;
                  end
                  slot0 = pct_pkg::make_tok(kw ? pct_pkg::KIND_KEYWORD : pct_pkg::KIND_IDENT,
                                            '0, kw ? 16'd0 : tlen_in, tline_in, tcol_in);
                  nres    = 2'd1;
                  mode_in = M_IDLE;
                  do_idle = 1'b1;
               end
            end
            M_STRING: begin
               if (ch == CH_NUL) begin
                  if (fkw_in) begin
                     slot0 = pct_pkg::make_tok(pct_pkg::KIND_ERROR, '0, '0, tline_in, tcol_in);
                     nres  = 2'd1;
                  end else begin
                     slot0 = pct_pkg::make_tok(pct_pkg::KIND_DROPPED, '0, tlen_in, tline_in,
                                               tcol_in);
                     slot1 = pct_pkg::make_tok(pct_pkg::KIND_END, '0, '0, line_in, col_in);
                     nres  = 2'd2;
                  end
                  mode_in = M_DONE;
               end else if (ch == CH_QUOTE && !esc_in) begin
                  if (!seen_in) begin
                     seen_in = 1'b1;
                     fkw_in  = 1'b0;
                  end
                  slot0   = pct_pkg::make_tok(pct_pkg::KIND_STRING, '0, tlen_in, tline_in,
                                              tcol_in);
                  nres    = 2'd1;
                  mode_in = M_IDLE;
               end else if (ch == CH_BSL) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in = 1'b0;
                  slot0  = pct_pkg::make_tok(pct_pkg::KIND_BODY, ch, '0, tline_in, tcol_in);
                  if (tlen_in != LEN_MAX) tlen_in = tlen_in + 16'd1;
                  nres = 2'd1;
               end
            end
            default: do_idle = 1'b1;
         endcase

         if (do_idle) begin
            if (is_blank) begin
               idle_hit = 1'b0;
            end else if (ch == CH_NUL) begin
               mode_in  = M_DONE;
               idle_hit = 1'b1;
               idle_tok = pct_pkg::make_tok(pct_pkg::KIND_END, '0, '0, line_in, col_in);
            end else if (is_letter) begin
               mode_in  = M_WORD;
               tline_in = line_in;
               tcol_in  = col_in;
               tlen_in  = 16'd1;
               kwm_in   = ch == pct_pkg::keyword_char(3'd0);
               idle_hit = 1'b1;
               idle_tok = pct_pkg::make_tok(pct_pkg::KIND_BODY, ch, '0, line_in, col_in);
            end else if (ch == CH_QUOTE) begin
               mode_in  = M_STRING;
               tline_in = line_in;
               tcol_in  = col_in;
               tlen_in  = '0;
               esc_in   = 1'b0;
            end else begin
               idle_hit = 1'b1;
               if (!seen_in) begin
                  seen_in = 1'b1;
                  fkw_in  = 1'b0;
               end
               if (ch == CH_OPEN)
                  idle_tok = pct_pkg::make_tok(pct_pkg::KIND_OPEN, '0, '0, line_in, col_in);
               else if (ch == CH_CLOSE)
                  idle_tok = pct_pkg::make_tok(pct_pkg::KIND_CLOSE, '0, '0, line_in, col_in);
               else if (ch == CH_COMMA)
                  idle_tok = pct_pkg::make_tok(pct_pkg::KIND_COMMA, '0, '0, line_in, col_in);
               else begin
                  mode_in  = M_DONE;
                  idle_tok = pct_pkg::make_tok(pct_pkg::KIND_GARBAGE, '0, '0, line_in,
                                               col_in);
               end
            end
            if (idle_hit) begin
               if (nres == 2'd0) begin
                  slot0 = idle_tok;
                  nres  = 2'd1;
               end else begin
                  slot1 = idle_tok;
                  nres  = 2'd2;
               end
            end
         end
      end
   end

   assign rec_push            = accept && nres != 2'd0;
   assign rec_data.two        = nres == 2'd2;
   assign rec_data.slot0      = slot0;
   assign rec_data.slot1      = slot1;
   assign rec_data.now_line   = line_in;
   assign rec_data.now_column = col_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff   <= pct_pkg::TAB_WIDTH_RESET;
         mode_ff  <= M_IDLE;
         line_ff  <= '0;
         col_ff   <= '0;
         tline_ff <= '0;
         tcol_ff  <= '0;
         tlen_ff  <= '0;
         kwm_ff   <= 1'b1;
         esc_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         fkw_ff   <= 1'b0;
      end else begin
         tab_ff <= tab_in;
         if (accept) begin
            mode_ff  <= mode_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            tline_ff <= tline_in;
            tcol_ff  <= tcol_in;
            tlen_ff  <= tlen_in;
            kwm_ff   <= kwm_in;
            esc_ff   <= esc_in;
            seen_ff  <= seen_in;
            fkw_ff   <= fkw_in;
         end
      end
   end

endmodule

// ===== sv/pct_queue.sv =====
// Short queue of result records between the front and back ends.
module pct_queue #(
   parameter int DEPTH = pct_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pct_pkg::rec_type  push_data,
   output logic              full,
   input  logic              pop,
   output pct_pkg::rec_type  head,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   pct_pkg::rec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop)  rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_W'(1);
      if (do_push && !do_pop)      count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

endmodule

// ===== sv/pct_back.sv =====
// Back end: holds one record and hands out its results one per transaction.
module pct_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              rec_empty,
   input  pct_pkg::rec_type  rec_data,
   output logic              rec_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pct_pkg::rsp_type  rsp_payload
);

   pct_pkg::rec_type hold_ff;
   logic             valid_ff, valid_in;
   logic             idx_ff, idx_in;
   logic             cur_last, free;
   pct_pkg::tok_type cur;

   assign cur_last = idx_ff || !hold_ff.two;
   assign free     = !valid_ff || (rsp_pop && cur_last);
   assign rec_pop  = free && !rec_empty;
   assign valid_in = free ? !rec_empty : valid_ff;

   always_comb begin
      idx_in = idx_ff;
      if (rec_pop) idx_in = 1'b0;
      else if (valid_ff && rsp_pop && !cur_last) idx_in = 1'b1;
   end

   assign cur                      = idx_ff ? hold_ff.slot1 : hold_ff.slot0;
   assign rsp_empty                = !valid_ff;
   assign rsp_payload.kind         = cur.kind;
   assign rsp_payload.data         = cur.data;
   assign rsp_payload.token_length = cur.token_length;
   assign rsp_payload.token_line   = cur.token_line;
   assign rsp_payload.token_column = cur.token_column;
   assign rsp_payload.now_line     = hold_ff.now_line;
   assign rsp_payload.now_column   = hold_ff.now_column;
   assign rsp_payload.last         = cur_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) hold_ff <= rec_data;
   end

endmodule

// ===== sv/pragma_comment_tokenizer.sv =====
// Top level of the pragma comment tokenizer: front end, record queue, back end.
//
//   channel  ports                             direction  moves
//   req      req_push / req_full / req_payload  in         one comment character
//   rsp      rsp_pop / rsp_empty / rsp_payload  out        one token result
//   csr      csr_valid / csr_ready / csr_data   in         tab width (7 bits)
//
// One character is taken every cycle while req_full is low; its state update
// is done in the cycle it is accepted. Each character yields zero, one or two
// results, kept as one record in a QUEUE_DEPTH-entry queue. The back end hands
// out one result per cycle while rsp_pop is high, so a character with two
// results occupies the output for two transactions. A result passes through
// a queue entry and then the back end's hold register before it shows on rsp.
// Reset is synchronous: it clears scan state, position and queue, and sets
// the tab width to 8. csr_ready is always high.
// req_full follows the queue alone; a stalled rsp side fills the queue and
// only then holds off the req side.
module pragma_comment_tokenizer #(
   parameter int QUEUE_DEPTH = pct_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  pct_pkg::req_type  req_payload,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pct_pkg::rsp_type  rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_data
);

   // records flowing front -> queue -> back
   logic             q_push, q_full, q_pop, q_empty;
   pct_pkg::rec_type q_wdata, q_head;

   pct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .csr_ready   (csr_ready),
      .rec_full    (q_full),
      .rec_push    (q_push),
      .rec_data    (q_wdata)
   );

   pct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   pct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .rec_empty   (q_empty),
      .rec_data    (q_head),
      .rec_pop     (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/pragma_comment_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pragma comment tokenizer: directed and random comments.
module pragma_comment_tokenizer_tb;

   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 12;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam logic [47:0] KEYWORD_TEXT = "pragma";

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_STRING, SCAN_DONE} scan_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   pct_pkg::req_type req_payload = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   pct_pkg::rsp_type rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [6:0]       csr_data    = '0;

   // tokenizer state as predicted
   logic [6:0]  tab_width;
   scan_type    scan;
   logic [23:0] line_no;
   logic [15:0] col_no;
   logic [23:0] tok_line;
   logic [15:0] tok_col;
   logic [15:0] tok_len;
   bit          kw_match;
   bit          esc_pending;
   bit          seen_token;
   bit          first_kw;

   pct_pkg::rsp_type expected_tokens[$];
   logic [7:0]  comment_buf[$];
   int          step_results;
   int          chars_taken;
   int          tokens_checked;
   int          tab_writes;
   int          error_count;

   // receiver hold-off: the test asks, the receiver counts
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;
   bit          steady        = 1'b0;

   pragma_comment_tokenizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- character classes ----------------

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_word_char(logic [7:0] c);
      return is_letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_DOLLAR;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR || c == CH_FF;
   endfunction

   // ---------------- tokenizer prediction ----------------

   function automatic void queue_token(logic [3:0] kind, logic [7:0] data, logic [15:0] len,
                                       logic [23:0] tl, logic [15:0] tc);
      pct_pkg::rsp_type r;
      r.kind         = kind;
      r.data         = data;
      r.token_length = len;
      r.token_line   = tl;
      r.token_column = tc;
      r.now_line     = line_no;
      r.now_column   = col_no;
      r.last         = 1'b0;
      expected_tokens.push_back(r);
      step_results++;
   endfunction

   function automatic void restart_comment(logic [23:0] sline, logic [15:0] scol);
      scan        = SCAN_IDLE;
      line_no     = sline;
      col_no      = scol;
      tok_line    = '0;
      tok_col     = '0;
      tok_len     = '0;
      kw_match    = 1'b1;
      esc_pending = 1'b0;
      seen_token  = 1'b0;
      first_kw    = 1'b0;
   endfunction

   function automatic void advance_position(logic [7:0] c);
      logic [16:0] sum;
      if (c == CH_NL) begin
         if (line_no != 24'hFFFFFF) line_no = line_no + 24'd1;
         col_no = '0;
      end else begin
         sum = {1'b0, col_no} + ((c == CH_TAB) ? 17'(tab_width) : 17'd1);
         col_no = sum[16] ? 16'hFFFF : sum[15:0];
      end
   endfunction

   function automatic void note_token(logic [3:0] kind);
      if (!seen_token) begin
         seen_token = 1'b1;
         first_kw   = (kind == pct_pkg::KIND_KEYWORD);
      end
   endfunction

   function automatic void keep_word_char(logic [7:0] c);
      int k;
      k = tok_len;
      if (k >= 6 || c != KEYWORD_TEXT[47 - 8*k -: 8]) kw_match = 1'b0;
      if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;
      queue_token(pct_pkg::KIND_BODY, c, 16'd0, tok_line, tok_col);
   endfunction

   function automatic void keep_string_char(logic [7:0] c);
      if (tok_len != 16'hFFFF) tok_len = tok_len + 16'd1;
      queue_token(pct_pkg::KIND_BODY, c, 16'd0, tok_line, tok_col);
   endfunction

   function automatic void single_token(logic [3:0] kind);
      note_token(kind);
      queue_token(kind, 8'h00, 16'd0, line_no, col_no);
   endfunction

   function automatic void idle_char(logic [7:0] c);
      if (is_blank(c)) return;
      if (c == CH_NUL) begin
         scan = SCAN_DONE;
         queue_token(pct_pkg::KIND_END, 8'h00, 16'd0, line_no, col_no);
      end else if (is_letter(c)) begin
         scan     = SCAN_WORD;
         tok_line = line_no;
         tok_col  = col_no;
         tok_len  = '0;
         kw_match = 1'b1;
         keep_word_char(c);
      end else if (c == CH_QUOTE) begin
         scan        = SCAN_STRING;
         tok_line    = line_no;
         tok_col     = col_no;
         tok_len     = '0;
         esc_pending = 1'b0;
      end else if (c == CH_LPAREN) begin
         single_token(pct_pkg::KIND_OPEN);
      end else if (c == CH_RPAREN) begin
         single_token(pct_pkg::KIND_CLOSE);
      end else if (c == CH_COMMA) begin
         single_token(pct_pkg::KIND_COMMA);
      end else begin
         scan = SCAN_DONE;
         single_token(pct_pkg::KIND_GARBAGE);
      end
   endfunction

   function automatic void tokenize_char(pct_pkg::req_type item);
      logic [7:0] c;
      bit         kw;
      c = item.ch;
      step_results = 0;
      if (item.first) restart_comment(item.start_line, item.start_column);
      if (scan == SCAN_DONE) return;
      advance_position(c);
      case (scan)
         SCAN_WORD: begin
            if (is_word_char(c)) begin
               keep_word_char(c);
            end else begin
               // the ender closes the word, then is taken as a fresh character
               kw = kw_match && tok_len == 16'd6;
               note_token(kw ? pct_pkg::KIND_KEYWORD : pct_pkg::KIND_IDENT);
               queue_token(kw ? pct_pkg::KIND_KEYWORD : pct_pkg::KIND_IDENT, 8'h00,
                           kw ? 16'd0 : tok_len, tok_line, tok_col);
               scan = SCAN_IDLE;
               idle_char(c);
            end
         end
         SCAN_STRING: begin
            if (c == CH_NUL) begin
               if (first_kw) begin
                  queue_token(pct_pkg::KIND_ERROR, 8'h00, 16'd0, tok_line, tok_col);
               end else begin
                  queue_token(pct_pkg::KIND_DROPPED, 8'h00, tok_len, tok_line, tok_col);
                  queue_token(pct_pkg::KIND_END, 8'h00, 16'd0, line_no, col_no);
               end
               scan = SCAN_DONE;
            end else if (c == CH_QUOTE && !esc_pending) begin
               note_token(pct_pkg::KIND_STRING);
               queue_token(pct_pkg::KIND_STRING, 8'h00, tok_len, tok_line, tok_col);
               scan = SCAN_IDLE;
            end else if (c == CH_BSLASH) begin
               esc_pending = 1'b1;
            end else begin
               esc_pending = 1'b0;
               keep_string_char(c);
            end
         end
         default: idle_char(c);
      endcase
      if (step_results != 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
   endfunction

   // ---------------- result checking and receiver ----------------

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      pct_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_tokens.size() == 0) begin
            $error("result with none expected: kind %0d data %0h",
                   rsp_payload.kind, rsp_payload.data);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("kind",         want.kind,         rsp_payload.kind);
            check_field("data",         want.data,         rsp_payload.data);
            check_field("token_length", want.token_length, rsp_payload.token_length);
            check_field("token_line",   want.token_line,   rsp_payload.token_line);
            check_field("token_column", want.token_column, rsp_payload.token_column);
            check_field("now_line",     want.now_line,     rsp_payload.now_line);
            check_field("now_column",   want.now_column,   rsp_payload.now_column);
            check_field("last",         want.last,         rsp_payload.last);
            tokens_checked++;
         end
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_pop     <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= steady || ($urandom_range(99) >= 16);
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'h61 + 8'($urandom_range(25));
      if ($urandom_range(1)) c = c - 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(3))
         0:       return rand_letter();
         1:       return 8'h30 + 8'($urandom_range(9));
         2:       return CH_UNDER;
         default: return CH_DOLLAR;
      endcase
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(4))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_NL;
         3:       return CH_CR;
         default: return CH_FF;
      endcase
   endfunction

   function automatic logic [7:0] rand_string_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function automatic logic [7:0] rand_garbage();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (is_letter(c) || is_blank(c) || c == CH_QUOTE || c == CH_LPAREN ||
             c == CH_RPAREN || c == CH_COMMA);
      return c;
   endfunction

   function automatic logic [23:0] rand_line();
      case ($urandom_range(3))
         0:       return 24'($urandom_range(100));
         1:       return 24'hFFFFFF - 24'($urandom_range(3));
         2:       return 24'($urandom);
         default: return 24'($urandom_range(5000));
      endcase
   endfunction

   function automatic logic [15:0] rand_column();
      case ($urandom_range(3))
         0:       return 16'($urandom_range(100));
         1:       return 16'hFFFF - 16'($urandom_range(40));
         2:       return 16'($urandom);
         default: return 16'($urandom_range(200));
      endcase
   endfunction

   function automatic void add_char(logic [7:0] c);
      comment_buf.push_back(c);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) comment_buf.push_back(s[i]);
   endfunction

   function automatic void add_string_body(int n);
      repeat (n) begin
         if ($urandom_range(5) == 0) begin
            add_char(CH_BSLASH);
            case ($urandom_range(2))
               0:       add_char(CH_QUOTE);
               1:       add_char(CH_BSLASH);
               default: add_char(rand_string_char());
            endcase
         end else begin
            add_char(rand_string_char());
         end
      end
   endfunction

   // Mostly well-formed comments with random content; some pure noise.
   function automatic void build_comment();
      int pick;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(1)) begin
         add_text("pragma");
         add_char($urandom_range(1) ? rand_blank() : CH_LPAREN);
      end
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(2) == 0) add_char(rand_blank());
         pick = $urandom_range(9);
         case (pick)
            0, 1, 2: begin
               add_char(rand_letter());
               repeat ($urandom_range(7)) add_char(rand_word_char());
            end
            3, 4: begin
               add_char(CH_QUOTE);
               add_string_body($urandom_range(6));
               add_char(CH_QUOTE);
            end
            5: add_char(CH_LPAREN);
            6: add_char(CH_RPAREN);
            7: add_char(CH_COMMA);
            8: begin
               // near misses of the keyword, and the keyword itself
               case ($urandom_range(3))
                  0:       add_text("pragm");
                  1:       add_text("pragmas");
                  2:       add_text("Pragma");
                  default: add_text("pragma");
               endcase
            end
            default: repeat ($urandom_range(1, 3)) add_char(rand_blank());
         endcase
      end
      pick = $urandom_range(19);
      if (pick < 13) begin
         add_char(CH_NUL);
      end else if (pick < 15) begin
         add_char(rand_garbage());
      end else if (pick < 19) begin
         // unterminated string
         add_char(CH_QUOTE);
         add_string_body($urandom_range(4));
         add_char(CH_NUL);
      end
      // trailing characters after the comment has stopped, or a cut-off comment
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_char(8'($urandom));
   endfunction

   task automatic send_char(input pct_pkg::req_type item);
      bit ignored;
      while (!steady && $urandom_range(99) < 16) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_full);
      ignored = !item.first && scan == SCAN_DONE;
      tokenize_char(item);
      if (!ignored) chars_taken++;
   endtask

   task automatic send_comment(input logic [23:0] sline, input logic [15:0] scol);
      pct_pkg::req_type item;
      for (int i = 0; i < comment_buf.size(); i++) begin
         item.ch           = comment_buf[i];
         item.first        = (i == 0);
         item.start_line   = (i == 0) ? sline : 24'($urandom);
         item.start_column = (i == 0) ? scol  : 16'($urandom);
         send_char(item);
      end
      comment_buf.delete();
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   task automatic set_tab_width(input logic [6:0] w);
      wait_drained();
      // characters with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tab_width = w;
      tab_writes++;
   endtask

   task automatic send_random(input int count);
      int target;
      target = chars_taken + count;
      while (chars_taken < target) begin
         build_comment();
         send_comment(rand_line(), rand_column());
      end
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      // keyword first, escaped quote, tab into column saturation, zero in string: error
      add_text("pragma");
      add_char(CH_QUOTE);
      add_char(CH_BSLASH);
      add_char(CH_QUOTE);
      add_char(CH_TAB);
      add_char(CH_NUL);
      send_comment(24'hFFFFFF, 16'hFFF0);
      // top-bit character as garbage, the rest ignored
      add_char(8'hFF);
      add_text("z");
      send_comment(24'h000000, 16'h0000);
      // punctuation, newline at line limit, escape of a plain char, dropped string
      add_char(CH_LPAREN);
      add_char(CH_COMMA);
      add_char(CH_RPAREN);
      add_char(CH_NL);
      add_char(CH_QUOTE);
      add_char(CH_BSLASH);
      add_text("q");
      add_char(CH_QUOTE);
      add_char(CH_QUOTE);
      add_char(CH_NUL);
      send_comment(24'hFFFFFF, 16'h0000);
      // identifier closed by a top-half character: two results from one char
      add_char(CH_FF);
      add_text("Q9_$");
      add_char(8'h80);
      send_comment(24'h000000, 16'hFFFF);
   endtask

   task automatic test_random_comments(input int count);
      send_random(count);
   endtask

   task automatic test_backpressure();
      hold_requests <= hold_requests + 1;
      repeat (40) add_char(rand_letter());
      add_char(CH_NUL);
      send_comment(rand_line(), rand_column());
   endtask

   task automatic test_sender_pause();
      send_random(40);
      wait_drained();
      send_random(40);
   endtask

   task automatic test_steady_stream(input int count);
      steady = 1'b1;
      send_random(count);
      steady = 1'b0;
   endtask

   initial begin
      tab_width = pct_pkg::TAB_WIDTH_RESET;
      restart_comment('0, '0);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_tab_width(7'd1);
      test_random_comments(180);
      set_tab_width(7'd64);
      test_backpressure();
      test_random_comments(150);
      set_tab_width(7'($urandom_range(2, 63)));
      test_sender_pause();
      test_steady_stream(150);
      set_tab_width(7'($urandom_range(2, 63)));
      test_random_comments(100);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d characters taken and %0d results checked, %0d tab width writes,",
               chars_taken, tokens_checked, tab_writes);
      $display("with output hold-off, drain pauses and line/column saturation.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
